// ----- sv/rgb565_to_uyvy_converter_core_macros.svh -----
// Assertion macros used by the RGB565 to UYVY converter word builder
`ifndef RGB565_TO_UYVY_CONVERTER_CORE_MACROS_SVH
`define RGB565_TO_UYVY_CONVERTER_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle
`define RGB2UV_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgb2uv assertion failed");

// Check that a condition implies another in the next cycle
`define RGB2UV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgb2uv assertion failed");

`endif

// ----- sv/rgb2uv_pkg.sv -----
// Types, constant tables and color math for the RGB565 to UYVY converter
`timescale 1ns / 1ps

package rgb2uv_pkg;

   localparam int QUEUE_DEPTH_DEF = 2;

   typedef struct packed {
      logic [15:0] pixel_even;
      logic [15:0] pixel_odd;
      logic        end_of_line;
      logic        end_of_frame;
   } req_word_type;

   typedef struct packed {
      logic [31:0] uyvy_word;
      logic        last_of_run;
      logic        line_done;
      logic        frame_done;
   } rsp_word_type;

   typedef struct packed {
      logic [4:0] r0;
      logic [4:0] b0;
      logic [4:0] y0;
      logic [4:0] r1;
      logic [4:0] b1;
      logic [4:0] y1;
      logic       eol;
      logic       eof;
      logic       dbl;
   } pair_job_type;

   typedef logic [31:0][20:0] luma_tab_type;
   typedef logic [31:0][7:0]  byte_tab_type;

   // round to 24 significant bits, ties to even
   function automatic logic [63:0] round24(input logic [63:0] p);
      logic [63:0] t;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      int          n;
      t = p;
      n = 0;
      for (int k = 0; k < 40; k++) begin
         if (t >= 64'd16777216) begin
            t = t >> 1;
            n = n + 1;
         end
      end
      if (n == 0) begin
         return p;
      end
      q    = p >> n;
      rem  = p & ((64'd1 << n) - 64'd1);
      half = 64'd1 << (n - 1);
      if (rem > half || (rem == half && q[0])) begin
         q = q + 64'd1;
      end
      return q << n;
   endfunction

   function automatic luma_tab_type build_luma(input logic [23:0] m, input int fb);
      luma_tab_type tab;
      logic [63:0]  p;
      for (int i = 0; i < 32; i++) begin
         p = round24({40'd0, m} * 64'(i));
         p = round24(p + (64'd1 << (fb - 1)));
         p = p >> fb;
         tab[i] = p[20:0];
      end
      return tab;
   endfunction

   function automatic byte_tab_type build_chroma(input logic [23:0] m);
      byte_tab_type tab;
      logic [63:0]  p;
      for (int i = 0; i < 32; i++) begin
         p = round24({40'd0, m} * 64'(i)) >> 21;
         tab[i] = p[7:0];
      end
      return tab;
   endfunction

   function automatic byte_tab_type build_y_out();
      byte_tab_type tab;
      int           v;
      for (int i = 0; i < 32; i++) begin
         v = 16 + (219 * i) / 32;
         tab[i] = 8'(v);
      end
      return tab;
   endfunction

   localparam luma_tab_type LUMA_R_TAB = build_luma(24'd10032775, 9);
   localparam luma_tab_type LUMA_G_TAB = build_luma(24'd9848226, 8);
   localparam luma_tab_type LUMA_B_TAB = build_luma(24'd15300821, 11);
   localparam byte_tab_type CHROMA_U_TAB = build_chroma(24'd9479127);
   localparam byte_tab_type CHROMA_V_TAB = build_chroma(24'd11962155);
   localparam byte_tab_type Y_OUT_TAB = build_y_out();

   function automatic logic [4:0] luma_index(input logic [15:0] px);
      logic [20:0] sum;
      sum = LUMA_R_TAB[px[15:11]] + LUMA_G_TAB[px[10:6]] + LUMA_B_TAB[px[4:0]];
      return sum[20:16];
   endfunction

   function automatic logic [7:0] chroma_val(input byte_tab_type tab,
                                             input logic [4:0] c,
                                             input logic [4:0] y);
      logic [5:0] d;
      logic [5:0] nd;
      logic [4:0] mag;
      logic [9:0] s;
      d   = {1'b0, c} - {1'b0, y};
      nd  = 6'd0 - d;
      mag = d[5] ? nd[4:0] : d[4:0];
      s   = d[5] ? (10'd128 - {2'b00, tab[mag]}) : (10'd128 + {2'b00, tab[mag]});
      if (s[9]) begin
         return 8'd0;
      end
      if (s[8]) begin
         return 8'd255;
      end
      return s[7:0];
   endfunction

endpackage

// ----- sv/rgb2uv_front.sv -----
// Input stage: takes pixel pairs, computes luma indexes, feeds the job queue
`timescale 1ns / 1ps

module rgb2uv_front
   import rgb2uv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   input  logic         double_width,
   input  logic         queue_full,
   output logic         push,
   output pair_job_type push_job
);

   logic         stage_valid_ff;
   logic         stage_valid_in;
   pair_job_type stage_job_ff;
   pair_job_type stage_job_in;
   logic         take;

   assign req_stall = stage_valid_ff && queue_full;
   assign take      = req_valid && !req_stall;
   assign push      = stage_valid_ff && !queue_full;
   assign push_job  = stage_job_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_job_in   = stage_job_ff;
      if (take) begin
         stage_valid_in   = 1'b1;
         stage_job_in.r0  = req_data.pixel_even[15:11];
         stage_job_in.b0  = req_data.pixel_even[4:0];
         stage_job_in.y0  = luma_index(req_data.pixel_even);
         stage_job_in.r1  = req_data.pixel_odd[15:11];
         stage_job_in.b1  = req_data.pixel_odd[4:0];
         stage_job_in.y1  = luma_index(req_data.pixel_odd);
         stage_job_in.eol = req_data.end_of_line;
         stage_job_in.eof = req_data.end_of_frame;
         stage_job_in.dbl = double_width;
      end else if (push) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_job_ff <= stage_job_in;
   end

endmodule

// ----- sv/rgb2uv_fifo.sv -----
// Short job queue between the input stage and the word builder
`timescale 1ns / 1ps

module rgb2uv_fifo
   import rgb2uv_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  pair_job_type push_job,
   input  logic         pop,
   output logic         full,
   output logic         not_empty,
   output pair_job_type head_job
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   pair_job_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff;
   logic [PTR_W-1:0]       wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff;
   logic [PTR_W-1:0]       rd_ptr_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- sv/rgb2uv_back.sv -----
// Word builder: turns queued jobs into UYVY output words
`timescale 1ns / 1ps
`include "rgb565_to_uyvy_converter_core_macros.svh"

module rgb2uv_back
   import rgb2uv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  pair_job_type head_job,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_word_type rsp_data_ff;
   rsp_word_type rsp_data_in;
   logic         phase_ff;
   logic         phase_in;
   logic         load_en;
   logic         fire;
   logic         first_half;
   logic [7:0]   y0o;
   logic [7:0]   y1o;
   logic [7:0]   u0;
   logic [7:0]   v0;
   logic [7:0]   u1;
   logic [7:0]   v1;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign y0o = Y_OUT_TAB[head_job.y0];
   assign y1o = Y_OUT_TAB[head_job.y1];
   assign u0  = chroma_val(CHROMA_U_TAB, head_job.b0, head_job.y0);
   assign v0  = chroma_val(CHROMA_V_TAB, head_job.r0, head_job.y0);
   assign u1  = chroma_val(CHROMA_U_TAB, head_job.b1, head_job.y1);
   assign v1  = chroma_val(CHROMA_V_TAB, head_job.r1, head_job.y1);

   assign load_en    = !rsp_valid_ff || !rsp_stall;
   assign fire       = load_en && head_valid;
   assign first_half = head_job.dbl && !phase_ff;
   assign pop        = fire && !first_half;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      phase_in     = phase_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         phase_in     = first_half;
         if (first_half) begin
            rsp_data_in.uyvy_word   = {y0o, v0, y0o, u0};
            rsp_data_in.last_of_run = 1'b0;
            rsp_data_in.line_done   = 1'b0;
            rsp_data_in.frame_done  = 1'b0;
         end else begin
            rsp_data_in.uyvy_word   = head_job.dbl ? {y1o, v1, y1o, u1}
                                                   : {y1o, v0, y0o, u0};
            rsp_data_in.last_of_run = 1'b1;
            rsp_data_in.line_done   = head_job.eol;
            rsp_data_in.frame_done  = head_job.eof;
         end
      end else if (load_en) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   `RGB2UV_ASSERT_SAME(a_phase_has_job, clock, reset, phase_ff, head_valid)
   `RGB2UV_ASSERT_NEXT(a_first_half_advances, clock, reset, fire && first_half, phase_ff)
   `RGB2UV_ASSERT_SAME(a_first_word_no_marks, clock, reset, rsp_valid_ff && !rsp_data_ff.last_of_run, !rsp_data_ff.line_done && !rsp_data_ff.frame_done)

endmodule

// ----- sv/rgb565_to_uyvy_converter_core.sv -----
// Top level of the RGB565 to UYVY 4:2:2 converter
`timescale 1ns / 1ps

// Converts pairs of RGB565 pixels into packed UYVY words.
// Input channel req_*: one word carries an even and an odd pixel plus row
// and frame end marks; it is taken when req_valid is high and req_stall low.
// Result channel rsp_*: one UYVY word per transfer, taken when rsp_valid is
// high and rsp_stall low. last_of_run marks the final word of a pair and
// carries the row and frame marks.
// csr_wr_en/csr_wr_data write double_width: 0 gives one word per pair
// (even pixel chroma), 1 gives one full word per pixel. Write it only while
// the block is empty.
// The first word of a pair passes the input stage register, the job queue
// and the output register. Throughput: one pair per cycle in packed mode
// while rsp_stall is low; in doubled mode each pair gives two words.
// A two-entry job queue between the luma stage and the word builder keeps
// input flowing while the receiver stalls; when it fills, req_stall rises.
// Reset (synchronous) empties the pipeline and clears double_width.
module rgb565_to_uyvy_converter_core
   import rgb2uv_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   logic         double_width_ff;
   logic         double_width_in;
   logic         queue_full;
   logic         queue_not_empty;
   logic         push;
   logic         pop;
   pair_job_type push_job;
   pair_job_type head_job;

   assign double_width_in = csr_wr_en ? csr_wr_data : double_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         double_width_ff <= 1'b0;
      end else begin
         double_width_ff <= double_width_in;
      end
   end

   rgb2uv_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .double_width (double_width_ff),
      .queue_full   (queue_full),
      .push         (push),
      .push_job     (push_job)
   );

   rgb2uv_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_job  (head_job)
   );

   rgb2uv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (queue_not_empty),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
